// ----- sv/assert_macros.svh -----
// Assertion shorthands for the crossover signal checkers.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MACS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("macs check failed");

// Next-cycle implication.
`define MACS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("macs check failed");

`endif

// ----- sv/macs_pkg.sv -----
// ----------------------------------------------------------------------------
// macs_pkg
// Shared types and constants of the moving-average crossover signal block.
// ----------------------------------------------------------------------------
package macs_pkg;

  localparam int SYM_W      = 16;
  localparam int PRICE_IN_W = 32;
  localparam int LEN_REG_W  = 9;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYMBOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SHORT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG   = 2'd2;

  localparam logic [SYM_W-1:0]     SYMBOL_RESET = 16'd0;
  localparam logic [LEN_REG_W-1:0] SHORT_RESET  = 9'd5;
  localparam logic [LEN_REG_W-1:0] LONG_RESET   = 9'd20;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ORD_EQUAL = 2'd0,
    ORD_ABOVE = 2'd1,
    ORD_BELOW = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    POS_FLAT  = 2'd0,
    POS_LONG  = 2'd1,
    POS_SHORT = 2'd2
  } pos_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_EXIT = 2'd0,
    DIR_BUY  = 2'd1,
    DIR_SELL = 2'd2
  } dir_t;

  // One evaluated tick handed from the front to the back.
  typedef struct packed {
    logic   valid;
    order_t order;
  } ord_req_t;

endpackage

// ----- sv/macs_if.sv -----
// ----------------------------------------------------------------------------
// macs_if
// Valid/ready channels: price ticks in, trade signals out.
// ----------------------------------------------------------------------------
interface macs_tick_if import macs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SYM_W-1:0]      tick_symbol;
  logic [PRICE_IN_W-1:0] price;

  modport source (output valid, output tick_symbol, output price, input ready);
  modport sink   (input valid, input tick_symbol, input price, output ready);
endinterface

interface macs_sig_if import macs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIR_W-1:0] direction;
  logic             last_of_run;

  modport source (output valid, output direction, output last_of_run, input ready);
  modport sink   (input valid, input direction, input last_of_run, output ready);
endinterface

// ----- sv/macs_ram.sv -----
// ----------------------------------------------------------------------------
// macs_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module macs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read of the slot being written returns the old word.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/macs_front.sv -----
// ----------------------------------------------------------------------------
// macs_front
// Tick filter, price history, running window sums and exact average compare.
// ----------------------------------------------------------------------------
module macs_front import macs_pkg::*; #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  macs_tick_if.sink             in_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [QCNT_W-1:0]     q_level,
  output ord_req_t              push
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int E_W    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = PRICE_BITS + ADDR_W;
  localparam int PROD_W = SUM_W + E_W;

  function automatic logic [E_W-1:0] eff_len(input logic [LEN_REG_W-1:0] v);
    if (v == '0) begin
      return E_W'(1);
    end else if (32'(v) > 32'(MAX_WINDOW)) begin
      return E_W'(MAX_WINDOW);
    end else begin
      return E_W'(v);
    end
  endfunction

  // Slot that lies back places behind ws, for back in 1..MAX_WINDOW.
  function automatic logic [ADDR_W-1:0] slot_back(input logic [ADDR_W-1:0] ws,
                                                   input logic [E_W-1:0]    back);
    logic [E_W:0] d;
    d = (E_W+1)'(ws) + (E_W+1)'(MAX_WINDOW) - (E_W+1)'(back);
    if (d >= (E_W+1)'(MAX_WINDOW)) begin
      d = d - (E_W+1)'(MAX_WINDOW);
    end
    return ADDR_W'(d);
  endfunction

  logic [SYM_W-1:0]     symbol_r;
  logic [LEN_REG_W-1:0] short_reg_r;
  logic [LEN_REG_W-1:0] long_reg_r;
  logic [E_W-1:0]       len_s;
  logic [E_W-1:0]       len_l;

  logic [ADDR_W-1:0]    ws_r;
  logic [E_W-1:0]       fill_r;
  logic [E_W-1:0]       fill_nxt;
  logic                 hist_clr;

  logic                 accept;
  logic                 match;
  logic [PRICE_BITS-1:0] price_w;
  logic [QCNT_W:0]      occupied;

  logic [PRICE_BITS-1:0] rd_s;
  logic [PRICE_BITS-1:0] rd_l;

  // stage 1: ring data arrives, sums update
  logic                  s1_valid_r;
  logic                  s1_eval_r;
  logic                  s1_sub_s_r;
  logic                  s1_sub_l_r;
  logic [PRICE_BITS-1:0] s1_price_r;
  logic [SUM_W-1:0]      short_total_r;
  logic [SUM_W-1:0]      long_total_r;
  logic [SUM_W-1:0]      short_total_nxt;
  logic [SUM_W-1:0]      long_total_nxt;

  // stage 2: cross products
  logic                  s2_valid_r;
  logic                  s3_valid_r;
  logic [PROD_W-1:0]     prod_a_r;
  logic [PROD_W-1:0]     prod_b_r;

  assign len_s = eff_len(short_reg_r);
  assign len_l = eff_len(long_reg_r);

  assign hist_clr = cfg_we && (cfg_index == CFG_IDX_SHORT || cfg_index == CFG_IDX_LONG);

  // Hold off a request unless the queue can take every tick in flight.
  assign occupied    = (QCNT_W+1)'(q_level) + (QCNT_W+1)'(s1_valid_r)
                     + (QCNT_W+1)'(s2_valid_r) + (QCNT_W+1)'(s3_valid_r);
  assign in_ch.ready = occupied < (QCNT_W+1)'(QUEUE_DEPTH);

  assign accept  = in_ch.valid && in_ch.ready;
  assign match   = accept && (in_ch.tick_symbol == symbol_r);
  assign price_w = PRICE_BITS'(in_ch.price);

  assign fill_nxt = (fill_r < len_l) ? fill_r + E_W'(1) : fill_r;

  macs_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_WINDOW)) u_ring_s (
    .clk   (clk),
    .we    (match),
    .waddr (ws_r),
    .wdata (price_w),
    .raddr (slot_back(ws_r, len_s)),
    .rdata (rd_s)
  );

  macs_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_WINDOW)) u_ring_l (
    .clk   (clk),
    .we    (match),
    .waddr (ws_r),
    .wdata (price_w),
    .raddr (slot_back(ws_r, len_l)),
    .rdata (rd_l)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_r    <= SYMBOL_RESET;
      short_reg_r <= SHORT_RESET;
      long_reg_r  <= LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_SYMBOL: symbol_r    <= cfg_data[SYM_W-1:0];
        CFG_IDX_SHORT:  short_reg_r <= cfg_data[LEN_REG_W-1:0];
        CFG_IDX_LONG:   long_reg_r  <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: store the price and advance the history pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r       <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= match;
      if (hist_clr) begin
        fill_r <= '0;
      end else if (match) begin
        fill_r <= fill_nxt;
        ws_r   <= (ws_r == ADDR_W'(MAX_WINDOW - 1)) ? '0 : ws_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (match) begin
      s1_price_r <= price_w;
      s1_sub_s_r <= fill_r >= len_s;
      s1_sub_l_r <= fill_r >= len_l;
      s1_eval_r  <= (len_s <= len_l) && (fill_nxt >= len_l);
    end
  end

  // Stage 1: drop the leaving prices, add the new one.
  assign short_total_nxt = short_total_r - (s1_sub_s_r ? SUM_W'(rd_s) : '0)
                         + SUM_W'(s1_price_r);
  assign long_total_nxt  = long_total_r - (s1_sub_l_r ? SUM_W'(rd_l) : '0)
                         + SUM_W'(s1_price_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_total_r <= '0;
      long_total_r  <= '0;
      s2_valid_r    <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && s1_eval_r;
      if (hist_clr) begin
        short_total_r <= '0;
        long_total_r  <= '0;
      end else if (s1_valid_r) begin
        short_total_r <= short_total_nxt;
        long_total_r  <= long_total_nxt;
      end
    end
  end

  // Stage 2: cross-multiply sums by the other window's length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r && (short_total_r != '0) && (long_total_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      prod_a_r <= PROD_W'(short_total_r) * PROD_W'(len_l);
      prod_b_r <= PROD_W'(long_total_r) * PROD_W'(len_s);
    end
  end

  // Stage 3: classify and hand to the queue.
  always_comb begin
    push.valid = s3_valid_r;
    if (prod_a_r > prod_b_r) begin
      push.order = ORD_ABOVE;
    end else if (prod_a_r < prod_b_r) begin
      push.order = ORD_BELOW;
    end else begin
      push.order = ORD_EQUAL;
    end
  end

endmodule

// ----- sv/macs_queue.sv -----
// ----------------------------------------------------------------------------
// macs_queue
// Short FIFO of classified ticks between the front and the signal issuer.
// ----------------------------------------------------------------------------
module macs_queue import macs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ord_req_t          push,
  input  logic              pop,
  output ord_req_t          head,
  output logic [QCNT_W-1:0] level
);

  order_t            q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  // The front never pushes without room, so push needs no full check.
  assign do_pop = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_mem_r[wr_ptr_r] <= push.order;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push.valid) - QCNT_W'(do_pop);
    end
  end

  assign head.valid = count_r != '0;
  assign head.order = q_mem_r[rd_ptr_r];
  assign level      = count_r;

endmodule

// ----- sv/macs_back.sv -----
// ----------------------------------------------------------------------------
// macs_back
// Signal issuer: tracks order and position, emits exit/buy/sell results.
// ----------------------------------------------------------------------------
module macs_back import macs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ord_req_t    head,
  output logic        pop,
  macs_sig_if.source  out_ch
);

  order_t prev_r,      prev_nxt;
  pos_t   pos_r,       pos_nxt;
  logic   pend_r,      pend_nxt;
  dir_t   pend_dir_r,  pend_dir_nxt;
  logic   out_valid_r, out_valid_nxt;
  dir_t   out_dir_r,   out_dir_nxt;
  logic   out_last_r,  out_last_nxt;

  logic   can_load;
  logic   up_cross;
  logic   dn_cross;
  logic   need_exit;
  dir_t   sig_dir;

  assign can_load  = !out_valid_r || out_ch.ready;
  assign up_cross  = (head.order == ORD_ABOVE) && (prev_r != ORD_ABOVE);
  assign dn_cross  = (head.order == ORD_BELOW) && (prev_r != ORD_BELOW);
  assign need_exit = (up_cross && pos_r == POS_SHORT) || (dn_cross && pos_r == POS_LONG);
  assign sig_dir   = up_cross ? DIR_BUY : DIR_SELL;

  always_comb begin
    pop           = 1'b0;
    prev_nxt      = prev_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    pend_dir_nxt  = pend_dir_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_dir_nxt   = out_dir_r;
    out_last_nxt  = out_last_r;
    if (pend_r) begin
      // second result of an exit-and-reverse tick
      if (can_load) begin
        out_valid_nxt = 1'b1;
        out_dir_nxt   = pend_dir_r;
        out_last_nxt  = 1'b1;
        pend_nxt      = 1'b0;
      end
    end else if (head.valid) begin
      if (!up_cross && !dn_cross) begin
        // no result: just record the order
        pop      = 1'b1;
        prev_nxt = head.order;
      end else if (can_load) begin
        pop           = 1'b1;
        prev_nxt      = head.order;
        pos_nxt       = up_cross ? POS_LONG : POS_SHORT;
        out_valid_nxt = 1'b1;
        if (need_exit) begin
          out_dir_nxt  = DIR_EXIT;
          out_last_nxt = 1'b0;
          pend_nxt     = 1'b1;
          pend_dir_nxt = sig_dir;
        end else begin
          out_dir_nxt  = sig_dir;
          out_last_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= ORD_EQUAL;
      pos_r       <= POS_FLAT;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_dir_r <= pend_dir_nxt;
    out_dir_r  <= out_dir_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.direction   = out_dir_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

// ----- sv/moving_average_crossover_signal_core.sv -----
// ----------------------------------------------------------------------------
// moving_average_crossover_signal_core
// Moving-average crossover signal generator over a filtered price tick stream.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  in_ch    in   valid/ready  tick_symbol[15:0], price[31:0]
//  out_ch   out  valid/ready  direction[1:0], last_of_run
//  cfg_*    in   cfg_we       cfg_index[1:0], cfg_data[15:0]
//
//  One tick per cycle while in_ch.ready is high; a tick's results pass the ring
//  read, sum update, cross multiply and queue before its output register.
//  An exit-and-reverse tick gives two results: the exit, then the reversing signal.
//  in_ch.ready drops when the 8-entry queue plus ticks in flight are full.
//  Synchronous reset clears control state; the price ring needs no clearing.
// ----------------------------------------------------------------------------
module moving_average_crossover_signal_core import macs_pkg::*; #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  macs_tick_if.sink             in_ch,
  macs_sig_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ord_req_t          push;
  ord_req_t          head;
  logic              pop;
  logic [QCNT_W-1:0] q_level;

  macs_front #(.MAX_WINDOW(MAX_WINDOW), .PRICE_BITS(PRICE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_level   (q_level),
    .push      (push)
  );

  macs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .level (q_level)
  );

  macs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- sv/macs_checker.sv -----
// ----------------------------------------------------------------------------
// macs_checker
// Port-level checks on the signal output of the crossover core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module macs_checker import macs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DIR_W-1:0] out_dir,
  input logic             out_last
);

  logic rev_signal;

  assign rev_signal = out_valid && out_last && (out_dir == DIR_BUY || out_dir == DIR_SELL);

  `MACS_ASSERT_NXT(a_valid_hold, out_valid && !out_ready, out_valid)

  // A result that is not the last of its tick is always the exit.
  `MACS_ASSERT_IMP(a_exit_not_last, out_valid && !out_last, out_dir == DIR_EXIT)

  // Once the exit is taken, the reversing signal follows right away.
  `MACS_ASSERT_NXT(a_exit_then_signal, out_valid && out_ready && !out_last, rev_signal)

endmodule

bind moving_average_crossover_signal_core macs_checker u_macs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_dir   (out_ch.direction),
  .out_last  (out_ch.last_of_run)
);
